FILE: rtl/jfps_pkg.sv
`timescale 1ns / 1ps
package jfps_pkg;

  localparam int DATA_W  = 32;
  localparam int DIM_W   = 11;
  localparam int DIFF_W  = 47;
  localparam int PROD_W  = 64;
  localparam int FRAC_W  = 16;

  localparam int QUEUE_DEPTH = 4;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int OUT_DEPTH   = 8;

  localparam int CFG_ADDR_W = 5;
  localparam int REG_IDX_W  = 3;

  localparam logic [REG_IDX_W-1:0] REG_COEF_SOUTH = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_COEF_NORTH = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_COEF_EAST  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_COEF_WEST  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_COEF_FORCE = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_ROWS       = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_COLS       = 3'd6;

  localparam logic [DIFF_W-1:0] DIFF_MAX = {DIFF_W{1'b1}};

  typedef struct packed {
    logic signed [DATA_W-1:0] coef_south;
    logic signed [DATA_W-1:0] coef_north;
    logic signed [DATA_W-1:0] coef_east;
    logic signed [DATA_W-1:0] coef_west;
    logic signed [DATA_W-1:0] coef_force;
    logic [DIM_W-1:0]         interior_rows;
    logic [DIM_W-1:0]         interior_cols;
  } cfg_t;

  typedef struct packed {
    logic emit;
    logic last;
    logic clr;
  } flags_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] south;
    logic signed [DATA_W-1:0] north;
    logic signed [DATA_W-1:0] east;
    logic signed [DATA_W-1:0] west;
    logic signed [DATA_W-1:0] center;
    logic signed [DATA_W-1:0] frc;
    flags_t                   flags;
  } op_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] new_value;
    logic [DIFF_W-1:0]        diff_sum;
    logic                     last;
  } result_t;

endpackage

FILE: rtl/jfps_ram.sv
`timescale 1ns / 1ps
module jfps_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1026
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read-first: a same-address write returns the old word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/jfps_fifo.sv
`timescale 1ns / 1ps
module jfps_fifo #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic [WIDTH-1:0]           wdata,
  input  logic                       pop,
  output logic [WIDTH-1:0]           rdata,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int AW    = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + AW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  assign rdata = mem[rd_ptr];
  assign empty = (count == '0);

endmodule

FILE: rtl/jfps_front.sv
`timescale 1ns / 1ps
module jfps_front #(
  parameter int MAX_COLS = 1024,
  parameter int MAX_ROWS = 1024
) (
  input  logic                              clk,
  input  logic                              rst,
  input  jfps_pkg::cfg_t                    cfg,
  input  logic                              push,
  output logic                              full,
  input  logic signed [jfps_pkg::DATA_W-1:0] cell_value,
  input  logic signed [jfps_pkg::DATA_W-1:0] force_value,
  input  logic [jfps_pkg::QCNT_W-1:0]       q_count,
  output jfps_pkg::op_t                     op,
  output logic                              op_valid
);

  import jfps_pkg::*;

  localparam int DEPTH = MAX_COLS + 2;
  localparam int CW    = $clog2(DEPTH);
  localparam int RW    = $clog2(MAX_ROWS + 2);
  localparam logic [CW-1:0] LAST_ADDR = CW'(DEPTH - 1);

  logic [RW-1:0] row;
  logic [RW-1:0] row_next;
  logic [CW-1:0] col;
  logic [CW-1:0] col_next;
  logic [RW-1:0] rows_eff;
  logic [RW-1:0] rows_p1;
  logic [CW-1:0] cols_eff;
  logic [CW-1:0] cols_p1;
  logic [CW-1:0] ei;
  logic          accept;
  logic          row_end;

  logic          clr_busy;
  logic [CW-1:0] clr_ptr;

  logic          s1_valid;
  logic [DATA_W-1:0] s1_cell;
  logic [CW-1:0] s1_addr;
  logic          s1_rowend;
  flags_t        s1_flags;
  logic [DATA_W-1:0] west;

  logic          mid_we;
  logic [CW-1:0] mid_waddr;
  logic [DATA_W-1:0] mid_wdata;
  logic [DATA_W-1:0] frc_wdata;
  logic          up_we;
  logic [CW-1:0] up_waddr;
  logic [DATA_W-1:0] up_wdata;
  logic [DATA_W-1:0] mid_rd;
  logic [DATA_W-1:0] east_rd;
  logic [DATA_W-1:0] up_rd;
  logic [DATA_W-1:0] frc_rd;

  // out-of-range sizes clamp to [1, max]
  always_comb begin
    if (cfg.interior_rows == '0) begin
      rows_eff = RW'(1);
    end else if (int'(cfg.interior_rows) > MAX_ROWS) begin
      rows_eff = RW'(MAX_ROWS);
    end else begin
      rows_eff = RW'(cfg.interior_rows);
    end
    if (cfg.interior_cols == '0) begin
      cols_eff = CW'(1);
    end else if (int'(cfg.interior_cols) > MAX_COLS) begin
      cols_eff = CW'(MAX_COLS);
    end else begin
      cols_eff = CW'(cfg.interior_cols);
    end
    rows_p1 = rows_eff + RW'(1);
    cols_p1 = cols_eff + CW'(1);
  end

  assign full   = clr_busy || ((int'(q_count) + int'(s1_valid)) >= QUEUE_DEPTH);
  assign accept = push && !full;
  assign row_end = (col >= cols_p1);
  assign ei = (col == LAST_ADDR) ? col : col + CW'(1);

  always_comb begin
    row_next = row;
    col_next = col;
    if (accept) begin
      if (row_end) begin
        col_next = '0;
        row_next = (row >= rows_p1) ? '0 : row + RW'(1);
      end else begin
        col_next = col + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row      <= '0;
      col      <= '0;
      clr_busy <= 1'b1;
      clr_ptr  <= '0;
      s1_valid <= 1'b0;
      west     <= '0;
    end else begin
      row      <= row_next;
      col      <= col_next;
      s1_valid <= accept;
      if (clr_busy) begin
        clr_ptr <= clr_ptr + CW'(1);
        if (clr_ptr == LAST_ADDR) begin
          clr_busy <= 1'b0;
        end
      end
      if (s1_valid) begin
        west <= s1_rowend ? '0 : mid_rd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cell        <= cell_value;
      s1_addr        <= col;
      s1_rowend      <= row_end;
      s1_flags.clr   <= (row == '0) && (col == '0);
      s1_flags.emit  <= (row >= RW'(2)) && (row <= rows_p1) && (col != '0) && (col < cols_p1);
      s1_flags.last  <= (row == rows_p1) && (col == cols_eff);
    end
  end

  assign mid_we    = clr_busy || accept;
  assign mid_waddr = clr_busy ? clr_ptr : col;
  assign mid_wdata = clr_busy ? '0 : cell_value;
  assign frc_wdata = clr_busy ? '0 : force_value;
  assign up_we     = clr_busy || s1_valid;
  assign up_waddr  = clr_busy ? clr_ptr : s1_addr;
  assign up_wdata  = clr_busy ? '0 : mid_rd;

  // middle row is held twice for the centre and east reads
  jfps_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_mid_c (
    .clk(clk), .we(mid_we), .waddr(mid_waddr), .wdata(mid_wdata),
    .raddr(col), .rdata(mid_rd)
  );

  jfps_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_mid_e (
    .clk(clk), .we(mid_we), .waddr(mid_waddr), .wdata(mid_wdata),
    .raddr(ei), .rdata(east_rd)
  );

  // upper row takes the old middle word in the cycle after the transfer
  jfps_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_up (
    .clk(clk), .we(up_we), .waddr(up_waddr), .wdata(up_wdata),
    .raddr(col), .rdata(up_rd)
  );

  jfps_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_frc (
    .clk(clk), .we(mid_we), .waddr(mid_waddr), .wdata(frc_wdata),
    .raddr(col), .rdata(frc_rd)
  );

  always_comb begin
    op.south  = s1_cell;
    op.north  = up_rd;
    op.east   = east_rd;
    op.west   = west;
    op.center = mid_rd;
    op.frc    = frc_rd;
    op.flags  = s1_flags;
  end

  assign op_valid = s1_valid;

`ifndef ASSERT_OFF
  a_queue_room: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> (int'(q_count) < QUEUE_DEPTH))
    else $error("front pushed into a full queue");

  a_clear_quiet: assert property (@(posedge clk) disable iff (rst)
    clr_busy |=> !s1_valid)
    else $error("item in flight during clearing pass");
`endif

endmodule

FILE: rtl/jfps_back.sv
`timescale 1ns / 1ps
module jfps_back (
  input  logic                              clk,
  input  logic                              rst,
  input  jfps_pkg::cfg_t                    cfg,
  input  jfps_pkg::op_t                     op,
  input  logic                              op_avail,
  output logic                              op_take,
  output jfps_pkg::result_t                 res,
  output logic                              res_empty,
  input  logic                              res_pop
);

  import jfps_pkg::*;

  localparam int OCNT_W = $clog2(OUT_DEPTH + 1);

  logic v1, v2, v3, v4, v5;
  flags_t f1, f2, f3, f4, f5;
  logic signed [DATA_W-1:0] c1, c2, c3, c4;

  logic signed [PROD_W-1:0] m_s, m_n, m_e, m_w, m_f;
  logic signed [PROD_W-1:0] p_s, p_n, p_e, p_w, p_f;
  logic signed [PROD_W-FRAC_W:0]   s01, s23;
  logic signed [PROD_W-FRAC_W-1:0] tf;
  logic signed [PROD_W-FRAC_W+2:0] sum3;
  logic signed [DATA_W-1:0] sat_next, sat4, sat5;
  logic signed [DATA_W:0]   diff_a, diff_b;
  logic [DATA_W:0]          ad5;

  logic [DIFF_W-1:0] acc;
  logic [DIFF_W-1:0] acc_base;
  logic [DIFF_W:0]   acc_sum;
  logic [DIFF_W-1:0] acc_next;

  logic              res_push;
  result_t           res_in;
  logic [OCNT_W-1:0] out_count;
  logic              res_pop_ok;

  assign op_take = op_avail &&
    ((int'(out_count) + $countones({v1, v2, v3, v4, v5})) < OUT_DEPTH);

  always_comb begin
    m_s = PROD_W'(cfg.coef_south) * PROD_W'(op.south);
    m_n = PROD_W'(cfg.coef_north) * PROD_W'(op.north);
    m_e = PROD_W'(cfg.coef_east)  * PROD_W'(op.east);
    m_w = PROD_W'(cfg.coef_west)  * PROD_W'(op.west);
    m_f = PROD_W'(cfg.coef_force) * PROD_W'(op.frc);
  end

  always_comb begin
    if (!sum3[PROD_W-FRAC_W+2] && (sum3[PROD_W-FRAC_W+1:DATA_W-1] != '0)) begin
      sat_next = {1'b0, {(DATA_W-1){1'b1}}};
    end else if (sum3[PROD_W-FRAC_W+2] && (sum3[PROD_W-FRAC_W+1:DATA_W-1] != '1)) begin
      sat_next = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      sat_next = sum3[DATA_W-1:0];
    end
  end

  assign diff_a = (DATA_W+1)'(sat4) - (DATA_W+1)'(c4);
  assign diff_b = (DATA_W+1)'(c4) - (DATA_W+1)'(sat4);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1  <= 1'b0;
      v2  <= 1'b0;
      v3  <= 1'b0;
      v4  <= 1'b0;
      v5  <= 1'b0;
      acc <= '0;
    end else begin
      v1 <= op_take;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      if (v5) begin
        acc <= acc_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    p_s <= m_s;
    p_n <= m_n;
    p_e <= m_e;
    p_w <= m_w;
    p_f <= m_f;
    c1  <= op.center;
    f1  <= op.flags;

    // >>> 16 is the upper product bits
    s01 <= (PROD_W-FRAC_W+1)'($signed(p_s[PROD_W-1:FRAC_W]))
         + (PROD_W-FRAC_W+1)'($signed(p_n[PROD_W-1:FRAC_W]));
    s23 <= (PROD_W-FRAC_W+1)'($signed(p_e[PROD_W-1:FRAC_W]))
         + (PROD_W-FRAC_W+1)'($signed(p_w[PROD_W-1:FRAC_W]));
    tf  <= $signed(p_f[PROD_W-1:FRAC_W]);
    c2  <= c1;
    f2  <= f1;

    sum3 <= (PROD_W-FRAC_W+3)'(s01) + (PROD_W-FRAC_W+3)'(s23)
          - (PROD_W-FRAC_W+3)'(tf);
    c3   <= c2;
    f3   <= f2;

    sat4 <= sat_next;
    c4   <= c3;
    f4   <= f3;

    ad5  <= diff_a[DATA_W] ? diff_b : diff_a;
    sat5 <= sat4;
    f5   <= f4;
  end

  always_comb begin
    acc_base = f5.clr ? '0 : acc;
    acc_sum  = (DIFF_W+1)'(acc_base) + (DIFF_W+1)'(ad5);
    if (f5.emit) begin
      acc_next = acc_sum[DIFF_W] ? DIFF_MAX : acc_sum[DIFF_W-1:0];
    end else begin
      acc_next = acc_base;
    end
  end

  assign res_push         = v5 && f5.emit;
  assign res_in.new_value = sat5;
  assign res_in.diff_sum  = acc_next;
  assign res_in.last      = f5.last;
  assign res_pop_ok       = res_pop && !res_empty;

  jfps_fifo #(.WIDTH($bits(result_t)), .DEPTH(OUT_DEPTH)) u_out_q (
    .clk(clk), .rst(rst),
    .push(res_push), .wdata(res_in),
    .pop(res_pop_ok), .rdata(res),
    .empty(res_empty), .count(out_count)
  );

`ifndef ASSERT_OFF
  a_credit: assert property (@(posedge clk) disable iff (rst)
    (int'(out_count) + $countones({v1, v2, v3, v4, v5})) <= OUT_DEPTH)
    else $error("result queue overcommitted");

  a_frame_clear: assert property (@(posedge clk) disable iff (rst)
    (v5 && f5.clr && !f5.emit) |=> (acc == '0))
    else $error("difference sum not cleared at frame start");
`endif

endmodule

FILE: rtl/jacobi_five_point_stencil_unit.sv
`timescale 1ns / 1ps
// channel   direction  handshake                  payload
// config    in         psel/penable/pwrite/pready paddr, pwdata, prdata
// cells     in         push / full                cell_value, force_value
// results   out        pop / empty                new_value, diff_sum, last
//
// One cell per cycle while full is low; the front line buffers and the back
// multiply pipeline each take a new cell every cycle unless full or out of room.
// Each result follows the transfer of the cell one row below it via both queues.
// After reset, full stays high while the line buffers clear.
// full rises once queued plus in-flight ops fill the 4-entry front-to-back queue;
// the back stops taking work when queued plus in-flight results reach 8.
module jacobi_five_point_stencil_unit #(
  parameter int MAX_COLS = 1024,
  parameter int MAX_ROWS = 1024
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [jfps_pkg::CFG_ADDR_W-1:0]        paddr,
  input  logic [jfps_pkg::DATA_W-1:0]            pwdata,
  output logic [jfps_pkg::DATA_W-1:0]            prdata,
  output logic                                   pready,
  input  logic                                   push,
  output logic                                   full,
  input  logic signed [jfps_pkg::DATA_W-1:0]     cell_value,
  input  logic signed [jfps_pkg::DATA_W-1:0]     force_value,
  output logic                                   empty,
  input  logic                                   pop,
  output logic signed [jfps_pkg::DATA_W-1:0]     new_value,
  output logic [jfps_pkg::DIFF_W-1:0]            diff_sum,
  output logic                                   last
);

  import jfps_pkg::*;

  cfg_t             cfg;
  logic [REG_IDX_W-1:0] reg_idx;
  op_t              op;
  logic             op_valid;
  logic [$bits(op_t)-1:0] q_head_bits;
  op_t              q_head;
  logic             q_empty;
  logic [QCNT_W-1:0] q_count;
  logic             q_take;
  result_t          res;

  assign pready  = 1'b1;
  assign reg_idx = paddr[CFG_ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.coef_south    <= '0;
      cfg.coef_north    <= '0;
      cfg.coef_east     <= '0;
      cfg.coef_west     <= '0;
      cfg.coef_force    <= '0;
      cfg.interior_rows <= DIM_W'(1);
      cfg.interior_cols <= DIM_W'(1);
    end else if (psel && penable && pwrite && pready) begin
      case (reg_idx)
        REG_COEF_SOUTH: cfg.coef_south    <= pwdata;
        REG_COEF_NORTH: cfg.coef_north    <= pwdata;
        REG_COEF_EAST:  cfg.coef_east     <= pwdata;
        REG_COEF_WEST:  cfg.coef_west     <= pwdata;
        REG_COEF_FORCE: cfg.coef_force    <= pwdata;
        REG_ROWS:       cfg.interior_rows <= pwdata[DIM_W-1:0];
        REG_COLS:       cfg.interior_cols <= pwdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_COEF_SOUTH: prdata = cfg.coef_south;
      REG_COEF_NORTH: prdata = cfg.coef_north;
      REG_COEF_EAST:  prdata = cfg.coef_east;
      REG_COEF_WEST:  prdata = cfg.coef_west;
      REG_COEF_FORCE: prdata = cfg.coef_force;
      REG_ROWS:       prdata = DATA_W'(cfg.interior_rows);
      REG_COLS:       prdata = DATA_W'(cfg.interior_cols);
      default:        prdata = '0;
    endcase
  end

  jfps_front #(.MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS)) u_front (
    .clk(clk), .rst(rst), .cfg(cfg),
    .push(push), .full(full),
    .cell_value(cell_value), .force_value(force_value),
    .q_count(q_count), .op(op), .op_valid(op_valid)
  );

  jfps_fifo #(.WIDTH($bits(op_t)), .DEPTH(QUEUE_DEPTH)) u_op_q (
    .clk(clk), .rst(rst),
    .push(op_valid), .wdata(op),
    .pop(q_take), .rdata(q_head_bits),
    .empty(q_empty), .count(q_count)
  );

  assign q_head = q_head_bits;

  jfps_back u_back (
    .clk(clk), .rst(rst), .cfg(cfg),
    .op(q_head), .op_avail(!q_empty), .op_take(q_take),
    .res(res), .res_empty(empty), .res_pop(pop)
  );

  assign new_value = res.new_value;
  assign diff_sum  = res.diff_sum;
  assign last      = res.last;

endmodule
